FILE: hw/rtl/p2d_pkg.sv
// Shared types, constants and helpers for the 2-D max/average pooling block.
// No dependencies; used by every module under hw/rtl.
`timescale 1ns / 1ps

package p2d_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int COL_BITS     = 10;
  localparam int ROW_BITS     = 10;
  localparam int WIDTH_BITS   = 11;
  localparam int IDX_BITS     = 11;
  localparam int POS_BITS     = 12;
  localparam int WIN_BITS     = 4;
  localparam int MARGIN_BITS  = 3;
  localparam int MAX_WINDOW   = 8;
  localparam int ROW_SEL_BITS = $clog2(MAX_WINDOW);
  localparam int MEM_DEPTH    = MAX_WINDOW * (2 ** COL_BITS);
  localparam int ADDR_BITS    = ROW_SEL_BITS + COL_BITS;
  localparam int MAX_RESULTS  = 64;
  localparam int CNT_BITS     = $clog2(MAX_RESULTS + 1);
  localparam int ACC_BITS     = SAMPLE_BITS + CNT_BITS;
  localparam int MAG_BITS     = ACC_BITS - 1;
  localparam int STEP_BITS    = $clog2(MAG_BITS + 1);
  localparam int MAX_PLANE    = 1024;
  localparam int MAX_STRIDE   = 8;
  localparam int FIFO_DEPTH   = 4;

  typedef enum logic [2:0] {
    REG_POOL_MODE     = 3'd0,
    REG_PLANE_HEIGHT  = 3'd1,
    REG_WINDOW_HEIGHT = 3'd2,
    REG_WINDOW_WIDTH  = 3'd3,
    REG_STEP_ROWS     = 3'd4,
    REG_STEP_COLS     = 3'd5,
    REG_MARGIN_ROWS   = 3'd6,
    REG_MARGIN_COLS   = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PICK,
    S_RD,
    S_ACC,
    S_DSET,
    S_DIV,
    S_RES,
    S_DONE
  } back_state_t;

  // effective (clamped) configuration
  typedef struct packed {
    logic                   avg;
    logic [WIDTH_BITS-1:0]  plane_height;
    logic [WIN_BITS-1:0]    window_height;
    logic [WIN_BITS-1:0]    window_width;
    logic [WIN_BITS-1:0]    step_rows;
    logic [WIN_BITS-1:0]    step_cols;
    logic [MARGIN_BITS-1:0] margin_rows;
    logic [MARGIN_BITS-1:0] margin_cols;
  } cfg_t;

  // one classified input item
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [COL_BITS-1:0]    col;
    logic [ROW_BITS-1:0]    row;
    logic [WIDTH_BITS-1:0]  width;
    logic                   row_en;
    logic                   row_multi;
    logic                   col_en;
    logic                   col_multi;
    logic [IDX_BITS-1:0]    oh;
    logic [IDX_BITS-1:0]    ow;
    logic [POS_BITS-1:0]    he;
    logic [POS_BITS-1:0]    we;
  } desc_t;

  function automatic logic [WIN_BITS-1:0] clamp_small(input logic [WIN_BITS-1:0] raw,
                                                      input logic [WIN_BITS-1:0] hi);
    logic [WIN_BITS-1:0] v;
    v = raw;
    if (raw == '0) v = WIN_BITS'(1);
    else if (raw > hi) v = hi;
    return v;
  endfunction

  function automatic logic [MARGIN_BITS-1:0] clamp_margin(input logic [MARGIN_BITS-1:0] raw,
                                                          input logic [WIN_BITS-1:0] win);
    logic [MARGIN_BITS-1:0] v;
    v = raw;
    if (WIN_BITS'(raw) >= win) v = MARGIN_BITS'(win - WIN_BITS'(1));
    return v;
  endfunction

endpackage

FILE: hw/rtl/p2d_front.sv
// Front end: tracks row/column position, learns the plane width and
// classifies each input item into a descriptor. Depends on p2d_pkg.
`timescale 1ns / 1ps

module p2d_front (
  input  logic                            clk,
  input  logic                            rst,
  input  p2d_pkg::cfg_t                   cfg,
  input  logic [p2d_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                            row_end,
  input  logic                            in_valid,
  output logic                            in_ready,
  output logic                            push_valid,
  input  logic                            push_ready,
  output p2d_pkg::desc_t                  push_desc
);

  logic [p2d_pkg::COL_BITS-1:0]   col;
  logic [p2d_pkg::ROW_BITS-1:0]   row;
  logic [p2d_pkg::WIDTH_BITS-1:0] lw;
  logic [p2d_pkg::IDX_BITS-1:0]   ow_next;
  logic [p2d_pkg::IDX_BITS-1:0]   oh_next;

  logic                           lw_known;
  logic [p2d_pkg::WIDTH_BITS-1:0] col_ext;
  logic                           term;
  logic                           last_row;
  logic [p2d_pkg::POS_BITS-1:0]   we_cur;
  logic [p2d_pkg::POS_BITS-1:0]   he_cur;
  logic                           col_hit;
  logic                           row_hit;
  logic                           take;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign take       = in_valid & push_ready;

  always_comb begin
    lw_known = (lw != '0);
    col_ext  = {1'b0, col} + p2d_pkg::WIDTH_BITS'(1);
    term     = row_end | (col == {p2d_pkg::COL_BITS{1'b1}}) | (lw_known & (col_ext >= lw));
    last_row = ({1'b0, row} >= (cfg.plane_height - p2d_pkg::WIDTH_BITS'(1)));
    we_cur   = p2d_pkg::POS_BITS'(ow_next) * p2d_pkg::POS_BITS'(cfg.step_cols)
             + p2d_pkg::POS_BITS'(cfg.window_width) - p2d_pkg::POS_BITS'(cfg.margin_cols)
             - p2d_pkg::POS_BITS'(1);
    he_cur   = p2d_pkg::POS_BITS'(oh_next) * p2d_pkg::POS_BITS'(cfg.step_rows)
             + p2d_pkg::POS_BITS'(cfg.window_height) - p2d_pkg::POS_BITS'(cfg.margin_rows)
             - p2d_pkg::POS_BITS'(1);
    col_hit  = (we_cur == p2d_pkg::POS_BITS'(col));
    row_hit  = (he_cur == p2d_pkg::POS_BITS'(row));

    push_desc.sample    = sample;
    push_desc.col       = col;
    push_desc.row       = row;
    push_desc.width     = lw_known ? lw : col_ext;
    push_desc.row_en    = last_row | row_hit;
    push_desc.row_multi = last_row;
    push_desc.col_en    = term | col_hit;
    push_desc.col_multi = term;
    push_desc.oh        = oh_next;
    push_desc.ow        = ow_next;
    push_desc.he        = he_cur;
    push_desc.we        = we_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      lw      <= '0;
      ow_next <= '0;
      oh_next <= '0;
    end else if (take) begin
      if (term) begin
        col     <= '0;
        ow_next <= '0;
        if (last_row) begin
          row     <= '0;
          lw      <= '0;
          oh_next <= '0;
        end else begin
          row <= row + p2d_pkg::ROW_BITS'(1);
          if (!lw_known) lw <= col_ext;
          if (row_hit) oh_next <= oh_next + p2d_pkg::IDX_BITS'(1);
        end
      end else begin
        col <= col + p2d_pkg::COL_BITS'(1);
        if (col_hit) ow_next <= ow_next + p2d_pkg::IDX_BITS'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/p2d_fifo.sv
// Short descriptor queue between the front and back ends.
// Depends on p2d_pkg for the descriptor type.
`timescale 1ns / 1ps

module p2d_fifo #(
  parameter int DEPTH = p2d_pkg::FIFO_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  p2d_pkg::desc_t push_desc,
  output logic           pop_valid,
  input  logic           pop_ready,
  output p2d_pkg::desc_t pop_desc
);

  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);

  p2d_pkg::desc_t      slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_desc   = slots[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      if (do_push && !do_pop) count <= count + CNT_W'(1);
      else if (do_pop && !do_push) count <= count - CNT_W'(1);
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

FILE: hw/rtl/p2d_back.sv
// Back end: owns the line store, walks the windows of each descriptor,
// reduces them (max or sum then serial divide) and drives the result port.
// Depends on p2d_pkg.
`timescale 1ns / 1ps

module p2d_back (
  input  logic                            clk,
  input  logic                            rst,
  input  p2d_pkg::cfg_t                   cfg,
  input  logic                            pop_valid,
  output logic                            pop_ready,
  input  p2d_pkg::desc_t                  pop_desc,
  output logic [p2d_pkg::SAMPLE_BITS-1:0] pooled_value,
  output logic [9:0]                      out_row,
  output logic [9:0]                      out_col,
  output logic                            burst_end,
  output logic                            plane_end,
  output logic                            out_valid,
  input  logic                            out_ready
);

  localparam int SB = p2d_pkg::SAMPLE_BITS;
  localparam int AB = p2d_pkg::ACC_BITS;
  localparam int MB = p2d_pkg::MAG_BITS;
  localparam int CB = p2d_pkg::CNT_BITS;
  localparam int PB = p2d_pkg::POS_BITS;

  p2d_pkg::back_state_t state, state_next;
  p2d_pkg::desc_t       d;

  logic [SB-1:0] mem [p2d_pkg::MEM_DEPTH];
  logic signed [SB-1:0] rdata;

  logic [p2d_pkg::IDX_BITS-1:0] oh, ow;
  logic [PB-1:0]                he, we;
  logic [p2d_pkg::ROW_BITS-1:0] ih;
  logic [p2d_pkg::COL_BITS-1:0] iw, c0, c1;
  logic signed [AB-1:0]         acc;
  logic [CB-1:0]                cnt;
  logic [CB-1:0]                nres;
  logic [MB-1:0]                mag, quo;
  logic [CB-1:0]                rem;
  logic                         neg;
  logic [p2d_pkg::STEP_BITS-1:0] step;

  logic          pend_valid;
  logic [SB-1:0] pend_value;
  logic [9:0]    pend_row, pend_col;
  logic          pend_plane;

  logic [PB-1:0]                row_lim, col_lim;
  logic                         row_ok, col_ok, cap_ok;
  logic [p2d_pkg::ROW_BITS-1:0] win_r0;
  logic [p2d_pkg::COL_BITS-1:0] win_c0, win_c1;
  logic [PB-1:0]                wmax;
  logic                         last_oh, last_ow;
  logic                         out_free;
  logic                         out_load;
  logic                         elem_last;
  logic signed [AB-1:0]         samp_ext;
  logic signed [SB-1:0]         samp_min;
  logic signed [AB-1:0]         acc_abs;
  logic [CB:0]                  trial;
  logic                         ge;
  logic [MB-1:0]                quo_s;
  logic [SB-1:0]                res_value;

  always_comb begin
    row_lim   = PB'(cfg.plane_height) - PB'(1) + PB'(cfg.margin_rows);
    col_lim   = PB'(d.width) - PB'(1) + PB'(cfg.margin_cols);
    row_ok    = (he <= row_lim);
    col_ok    = (we <= col_lim);
    cap_ok    = (nres < CB'(p2d_pkg::MAX_RESULTS));
    win_r0    = (he + PB'(1) < PB'(cfg.window_height)) ? '0
              : p2d_pkg::ROW_BITS'(he + PB'(1) - PB'(cfg.window_height));
    win_c0    = (we + PB'(1) < PB'(cfg.window_width)) ? '0
              : p2d_pkg::COL_BITS'(we + PB'(1) - PB'(cfg.window_width));
    wmax      = PB'(d.width) - PB'(1);
    win_c1    = (we < wmax) ? p2d_pkg::COL_BITS'(we) : p2d_pkg::COL_BITS'(wmax);
    last_oh   = (he + PB'(cfg.step_rows)) > row_lim;
    last_ow   = (we + PB'(cfg.step_cols)) > col_lim;
    out_free  = !out_valid | out_ready;
    out_load  = pend_valid && out_free &&
                (state == p2d_pkg::S_RES || state == p2d_pkg::S_DONE);
    elem_last = (iw == c1) && (ih == d.row);
    samp_ext  = AB'(rdata);
    samp_min  = {1'b1, {(SB-1){1'b0}}};
    acc_abs   = acc[AB-1] ? -acc : acc;
    trial     = {rem, mag[MB-1]};
    ge        = (trial >= {1'b0, cnt});
    quo_s     = neg ? -quo : quo;
    res_value = cfg.avg ? quo_s[SB-1:0] : acc[SB-1:0];
  end

  always_comb begin
    state_next = state;
    pop_ready  = 1'b0;
    case (state)
      p2d_pkg::S_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid && pop_desc.row_en && pop_desc.col_en) state_next = p2d_pkg::S_PICK;
      end
      p2d_pkg::S_PICK: begin
        if (!row_ok || !cap_ok) state_next = p2d_pkg::S_DONE;
        else if (!col_ok) begin
          if (!d.row_multi) state_next = p2d_pkg::S_DONE;
        end else state_next = p2d_pkg::S_RD;
      end
      p2d_pkg::S_RD: state_next = p2d_pkg::S_ACC;
      p2d_pkg::S_ACC: begin
        if (!elem_last) state_next = p2d_pkg::S_RD;
        else if (cfg.avg) state_next = p2d_pkg::S_DSET;
        else state_next = p2d_pkg::S_RES;
      end
      p2d_pkg::S_DSET: state_next = p2d_pkg::S_DIV;
      p2d_pkg::S_DIV: begin
        if (step == p2d_pkg::STEP_BITS'(1)) state_next = p2d_pkg::S_RES;
      end
      p2d_pkg::S_RES: begin
        if (!pend_valid || out_free) begin
          if (d.col_multi || d.row_multi) state_next = p2d_pkg::S_PICK;
          else state_next = p2d_pkg::S_DONE;
        end
      end
      p2d_pkg::S_DONE: begin
        if (!pend_valid || out_free) state_next = p2d_pkg::S_IDLE;
      end
      default: state_next = p2d_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= p2d_pkg::S_IDLE;
    else state <= state_next;
  end

  // line store
  always_ff @(posedge clk) begin
    if (state == p2d_pkg::S_IDLE && pop_valid) begin
      mem[{pop_desc.row[p2d_pkg::ROW_SEL_BITS-1:0], pop_desc.col}] <= pop_desc.sample;
    end
    if (state == p2d_pkg::S_RD) begin
      rdata <= mem[{ih[p2d_pkg::ROW_SEL_BITS-1:0], iw}];
    end
  end

  // window walk and reduction
  always_ff @(posedge clk) begin
    case (state)
      p2d_pkg::S_IDLE: begin
        if (pop_valid) begin
          d    <= pop_desc;
          oh   <= pop_desc.oh;
          he   <= pop_desc.he;
          ow   <= pop_desc.ow;
          we   <= pop_desc.we;
          nres <= '0;
        end
      end
      p2d_pkg::S_PICK: begin
        if (row_ok && cap_ok) begin
          if (!col_ok) begin
            oh <= oh + p2d_pkg::IDX_BITS'(1);
            he <= he + PB'(cfg.step_rows);
            ow <= d.ow;
            we <= d.we;
          end else begin
            ih  <= win_r0;
            iw  <= win_c0;
            c0  <= win_c0;
            c1  <= win_c1;
            cnt <= '0;
            acc <= cfg.avg ? '0 : AB'(samp_min);
          end
        end
      end
      p2d_pkg::S_ACC: begin
        cnt <= cnt + CB'(1);
        if (cfg.avg) acc <= acc + samp_ext;
        else if (samp_ext > acc) acc <= samp_ext;
        if (iw == c1) begin
          iw <= c0;
          ih <= ih + p2d_pkg::ROW_BITS'(1);
        end else begin
          iw <= iw + p2d_pkg::COL_BITS'(1);
        end
      end
      p2d_pkg::S_DSET: begin
        neg  <= acc[AB-1];
        mag  <= acc_abs[MB-1:0];
        rem  <= '0;
        quo  <= '0;
        step <= p2d_pkg::STEP_BITS'(MB);
      end
      p2d_pkg::S_DIV: begin
        rem  <= ge ? CB'(trial - {1'b0, cnt}) : trial[CB-1:0];
        quo  <= {quo[MB-2:0], ge};
        mag  <= {mag[MB-2:0], 1'b0};
        step <= step - p2d_pkg::STEP_BITS'(1);
      end
      p2d_pkg::S_RES: begin
        if (!pend_valid || out_free) begin
          pend_value <= res_value;
          pend_row   <= oh[9:0];
          pend_col   <= ow[9:0];
          pend_plane <= last_oh & last_ow;
          nres       <= nres + CB'(1);
          if (d.col_multi) begin
            ow <= ow + p2d_pkg::IDX_BITS'(1);
            we <= we + PB'(cfg.step_cols);
          end else if (d.row_multi) begin
            oh <= oh + p2d_pkg::IDX_BITS'(1);
            he <= he + PB'(cfg.step_rows);
            ow <= d.ow;
            we <= d.we;
          end
        end
      end
      default: ;
    endcase
  end

  // result hold stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (state == p2d_pkg::S_RES && (!pend_valid || out_free)) begin
        pend_valid <= 1'b1;
      end else if (state == p2d_pkg::S_DONE && pend_valid && out_free) begin
        pend_valid <= 1'b0;
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (out_load) begin
        pooled_value <= pend_value;
        out_row      <= pend_row;
        out_col      <= pend_col;
        plane_end    <= pend_plane;
        burst_end    <= (state == p2d_pkg::S_DONE);
      end
    end
  end

`ifndef SYNTH
  a_idle_flushed: assert property (@(posedge clk) disable iff (rst)
    (state == p2d_pkg::S_IDLE) |-> !pend_valid)
    else $error("held result left behind at end of transfer burst");
  a_result_cap: assert property (@(posedge clk) disable iff (rst)
    (state != p2d_pkg::S_IDLE) |-> (nres <= CB'(p2d_pkg::MAX_RESULTS)))
    else $error("too many results for one transfer");
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == p2d_pkg::S_DSET) |-> (cnt != '0))
    else $error("average of empty window");
`endif

endmodule

FILE: hw/rtl/pool2d_max_or_average.sv
// Top level of the 2-D max/average pooling block: configuration registers,
// front end, descriptor queue and back end. Depends on p2d_pkg and all p2d_* modules.
//
//  port group  dir  transfer when          payload
//  in          in   in_valid & in_ready    sample, row_end
//  out         out  out_valid & out_ready  pooled_value, out_row, out_col, burst_end, plane_end
//  apb         in   psel&penable&pwrite    paddr, pwdata (8 registers at 4*i)
//
// The front end classifies each input into a descriptor; the back end then walks
// each window sample through S_RD and S_ACC on the single line-store read port, and
// in average mode each window also passes S_DSET and S_DIV for the serial divider.
// Reset is synchronous and needs no clearing pass; the queue lets input transfers
// continue while the back end waits on out_ready.
`timescale 1ns / 1ps

module pool2d_max_or_average #(
  parameter int FIFO_DEPTH = p2d_pkg::FIFO_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [4:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic [p2d_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                            row_end,
  input  logic                            in_valid,
  output logic                            in_ready,
  output logic [p2d_pkg::SAMPLE_BITS-1:0] pooled_value,
  output logic [9:0]                      out_row,
  output logic [9:0]                      out_col,
  output logic                            burst_end,
  output logic                            plane_end,
  output logic                            out_valid,
  input  logic                            out_ready
);

  logic                               pool_mode;
  logic [p2d_pkg::WIDTH_BITS-1:0]     plane_height;
  logic [p2d_pkg::WIN_BITS-1:0]       window_height, window_width, step_rows, step_cols;
  logic [p2d_pkg::MARGIN_BITS-1:0]    margin_rows, margin_cols;
  p2d_pkg::reg_idx_t                  reg_sel;
  p2d_pkg::cfg_t                      cfg;
  logic                               wr_en;

  logic           push_valid, push_ready, pop_valid, pop_ready;
  p2d_pkg::desc_t push_desc, pop_desc;

  assign pready  = 1'b1;
  assign reg_sel = p2d_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_mode     <= 1'b0;
      plane_height  <= p2d_pkg::WIDTH_BITS'(1);
      window_height <= p2d_pkg::WIN_BITS'(2);
      window_width  <= p2d_pkg::WIN_BITS'(2);
      step_rows     <= p2d_pkg::WIN_BITS'(2);
      step_cols     <= p2d_pkg::WIN_BITS'(2);
      margin_rows   <= '0;
      margin_cols   <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        p2d_pkg::REG_POOL_MODE:     pool_mode     <= pwdata[0];
        p2d_pkg::REG_PLANE_HEIGHT:  plane_height  <= pwdata[p2d_pkg::WIDTH_BITS-1:0];
        p2d_pkg::REG_WINDOW_HEIGHT: window_height <= pwdata[p2d_pkg::WIN_BITS-1:0];
        p2d_pkg::REG_WINDOW_WIDTH:  window_width  <= pwdata[p2d_pkg::WIN_BITS-1:0];
        p2d_pkg::REG_STEP_ROWS:     step_rows     <= pwdata[p2d_pkg::WIN_BITS-1:0];
        p2d_pkg::REG_STEP_COLS:     step_cols     <= pwdata[p2d_pkg::WIN_BITS-1:0];
        p2d_pkg::REG_MARGIN_ROWS:   margin_rows   <= pwdata[p2d_pkg::MARGIN_BITS-1:0];
        p2d_pkg::REG_MARGIN_COLS:   margin_cols   <= pwdata[p2d_pkg::MARGIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      p2d_pkg::REG_POOL_MODE:     prdata = 32'(pool_mode);
      p2d_pkg::REG_PLANE_HEIGHT:  prdata = 32'(plane_height);
      p2d_pkg::REG_WINDOW_HEIGHT: prdata = 32'(window_height);
      p2d_pkg::REG_WINDOW_WIDTH:  prdata = 32'(window_width);
      p2d_pkg::REG_STEP_ROWS:     prdata = 32'(step_rows);
      p2d_pkg::REG_STEP_COLS:     prdata = 32'(step_cols);
      p2d_pkg::REG_MARGIN_ROWS:   prdata = 32'(margin_rows);
      p2d_pkg::REG_MARGIN_COLS:   prdata = 32'(margin_cols);
      default:                    prdata = '0;
    endcase
  end

  always_comb begin
    cfg.avg = pool_mode;
    if (plane_height == '0) cfg.plane_height = p2d_pkg::WIDTH_BITS'(1);
    else if (plane_height > p2d_pkg::WIDTH_BITS'(p2d_pkg::MAX_PLANE))
      cfg.plane_height = p2d_pkg::WIDTH_BITS'(p2d_pkg::MAX_PLANE);
    else cfg.plane_height = plane_height;
    cfg.window_height = p2d_pkg::clamp_small(window_height, p2d_pkg::WIN_BITS'(p2d_pkg::MAX_WINDOW));
    cfg.window_width  = p2d_pkg::clamp_small(window_width, p2d_pkg::WIN_BITS'(p2d_pkg::MAX_WINDOW));
    cfg.step_rows     = p2d_pkg::clamp_small(step_rows, p2d_pkg::WIN_BITS'(p2d_pkg::MAX_STRIDE));
    cfg.step_cols     = p2d_pkg::clamp_small(step_cols, p2d_pkg::WIN_BITS'(p2d_pkg::MAX_STRIDE));
    cfg.margin_rows   = p2d_pkg::clamp_margin(margin_rows, cfg.window_height);
    cfg.margin_cols   = p2d_pkg::clamp_margin(margin_cols, cfg.window_width);
  end

  p2d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .sample     (sample),
    .row_end    (row_end),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc)
  );

  p2d_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_desc   (pop_desc)
  );

  p2d_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_desc     (pop_desc),
    .pooled_value (pooled_value),
    .out_row      (out_row),
    .out_col      (out_col),
    .burst_end    (burst_end),
    .plane_end    (plane_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

endmodule

FILE: verif/pool2d_window_checker.sv
// Checker for pool2d_max_or_average: watches the APB writes and both streams,
// predicts every pooled window and compares field by field. Depends on p2d_pkg.
`timescale 1ns / 1ps

module pool2d_window_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [4:0]                      paddr,
  input  logic [31:0]                     pwdata,
  input  logic                            pready,
  input  logic [p2d_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                            row_end,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [p2d_pkg::SAMPLE_BITS-1:0] pooled_value,
  input  logic [9:0]                      out_row,
  input  logic [9:0]                      out_col,
  input  logic                            burst_end,
  input  logic                            plane_end,
  input  logic                            out_valid,
  input  logic                            out_ready,
  output int                              failures,
  output int                              pending
);

  typedef struct {
    logic [p2d_pkg::SAMPLE_BITS-1:0] value;
    logic [9:0]                      row;
    logic [9:0]                      col;
    logic                            burst;
    logic                            last;
  } window_t;

  window_t expected_windows[$];

  logic [p2d_pkg::SAMPLE_BITS-1:0] rows_kept[p2d_pkg::MAX_WINDOW][1024];
  int col_pos, row_pos, seen_width;
  int avg_mode, plane_rows, win_h, win_w, stride_r, stride_c, pad_r, pad_c;

  assign pending = expected_windows.size();

  function automatic int lim(input int v, input int lo, input int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    failures++;
  endtask

  task automatic predict_windows(input logic [p2d_pkg::SAMPLE_BITS-1:0] smp, input logic re);
    int hh, kh, kw, sh, sw, ph, pw, r, c, wd, out_h, out_w, lo, hi, num, base, n;
    int hs, he, ws, we, c0, cnt;
    bit term;
    longint acc, v;
    window_t w;
    hh = lim(plane_rows, 1, p2d_pkg::MAX_PLANE);
    kh = lim(win_h, 1, p2d_pkg::MAX_WINDOW);
    kw = lim(win_w, 1, p2d_pkg::MAX_WINDOW);
    sh = lim(stride_r, 1, p2d_pkg::MAX_STRIDE);
    sw = lim(stride_c, 1, p2d_pkg::MAX_STRIDE);
    ph = pad_r < kh ? pad_r : kh - 1;
    pw = pad_c < kw ? pad_c : kw - 1;
    r = row_pos;
    c = col_pos;
    n = 0;
    base = expected_windows.size();
    rows_kept[r % p2d_pkg::MAX_WINDOW][c] = smp;
    term = re || c >= 1023 || (seen_width != 0 && c + 1 >= seen_width);
    if (term && seen_width == 0) seen_width = c + 1;
    wd = seen_width != 0 ? seen_width : c + 1;
    out_h = (hh + 2 * ph >= kh) ? (hh + 2 * ph - kh) / sh + 1 : 0;
    out_w = (wd + 2 * pw >= kw) ? (wd + 2 * pw - kw) / sw + 1 : 0;
    if (term) begin
      lo = 0;
      hi = out_w - 1;
    end else begin
      num = c + pw + 1 - kw;
      if (num >= 0 && num % sw == 0) begin
        lo = num / sw;
        hi = lo;
      end else begin
        lo = 1;
        hi = 0;
      end
    end
    for (int oh = 0; oh < out_h; oh++) begin
      hs = oh * sh - ph;
      he = hs + kh - 1;
      if (he > hh - 1) he = hh - 1;
      if (he != r) continue;
      for (int ow = lo; ow <= hi; ow++) begin
        ws = ow * sw - pw;
        we = ws + kw - 1;
        if (we > wd - 1) we = wd - 1;
        if (term ? (we < c) : (we != c)) continue;
        if (n >= p2d_pkg::MAX_RESULTS) continue;
        c0 = ws < 0 ? 0 : ws;
        acc = avg_mode ? 0 : -(longint'(1) << (p2d_pkg::SAMPLE_BITS - 1));
        cnt = 0;
        for (int ih = (hs < 0 ? 0 : hs); ih <= he; ih++) begin
          for (int iw = c0; iw <= we; iw++) begin
            if (iw >= 1024) continue;
            v = longint'($signed(rows_kept[ih % p2d_pkg::MAX_WINDOW][iw]));
            if (avg_mode) acc += v;
            else if (v > acc) acc = v;
            cnt++;
          end
        end
        if (avg_mode && cnt > 0) acc = acc / cnt;
        w.value = acc[p2d_pkg::SAMPLE_BITS-1:0];
        w.row = oh[9:0];
        w.col = ow[9:0];
        w.burst = 1'b0;
        w.last = (oh == out_h - 1 && ow == out_w - 1);
        expected_windows.push_back(w);
        n++;
      end
    end
    if (n > 0) expected_windows[base + n - 1].burst = 1'b1;
    if (term) begin
      col_pos = 0;
      if (r >= hh - 1) begin
        row_pos = 0;
        seen_width = 0;
      end else begin
        row_pos = r + 1;
      end
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic compare_window();
    window_t w;
    if (expected_windows.size() == 0) begin
      report_mismatch($sformatf("unexpected window value %0d row %0d col %0d",
                                $signed(pooled_value), out_row, out_col));
      return;
    end
    w = expected_windows.pop_front();
    if (pooled_value !== w.value)
      report_mismatch($sformatf("value %0d, want %0d (row %0d col %0d)",
                                $signed(pooled_value), $signed(w.value), w.row, w.col));
    if (out_row !== w.row) report_mismatch($sformatf("out_row %0d, want %0d", out_row, w.row));
    if (out_col !== w.col) report_mismatch($sformatf("out_col %0d, want %0d", out_col, w.col));
    if (burst_end !== w.burst)
      report_mismatch($sformatf("burst_end %0b, want %0b", burst_end, w.burst));
    if (plane_end !== w.last)
      report_mismatch($sformatf("plane_end %0b, want %0b", plane_end, w.last));
  endtask

  initial failures = 0;

  always @(posedge clk) begin
    if (rst) begin
      col_pos = 0;
      row_pos = 0;
      seen_width = 0;
      avg_mode = 0;
      plane_rows = 1;
      win_h = 2;
      win_w = 2;
      stride_r = 2;
      stride_c = 2;
      pad_r = 0;
      pad_c = 0;
      expected_windows.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (p2d_pkg::reg_idx_t'(paddr[4:2]))
          p2d_pkg::REG_POOL_MODE:     avg_mode   = pwdata[0];
          p2d_pkg::REG_PLANE_HEIGHT:  plane_rows = pwdata[10:0];
          p2d_pkg::REG_WINDOW_HEIGHT: win_h      = pwdata[3:0];
          p2d_pkg::REG_WINDOW_WIDTH:  win_w      = pwdata[3:0];
          p2d_pkg::REG_STEP_ROWS:     stride_r   = pwdata[3:0];
          p2d_pkg::REG_STEP_COLS:     stride_c   = pwdata[3:0];
          p2d_pkg::REG_MARGIN_ROWS:   pad_r      = pwdata[2:0];
          p2d_pkg::REG_MARGIN_COLS:   pad_c      = pwdata[2:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) compare_window();
      if (in_valid && in_ready) predict_windows(sample, row_end);
    end
  end

endmodule

FILE: verif/tb_pool2d_max_or_average.sv
// Testbench top for pool2d_max_or_average: drives APB writes and sample rows,
// random idling and backpressure; depends on p2d_pkg and pool2d_window_checker.
`timescale 1ns / 1ps

module tb_pool2d_max_or_average;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic [p2d_pkg::SAMPLE_BITS-1:0] sample = '0;
  logic row_end = 1'b0, in_valid = 1'b0, in_ready;
  logic [p2d_pkg::SAMPLE_BITS-1:0] pooled_value;
  logic [9:0] out_row, out_col;
  logic burst_end, plane_end, out_valid;
  logic out_ready = 1'b0;
  int failures, pending;

  // stimulus-side view of the plane position, to keep early row ends legal
  int pc, pr, lw, plane_rows_raw, fed;
  int prefix_len[p2d_pkg::MAX_WINDOW];
  bit plane_done, idle_on, stall_on;
  int hold_len;

  pool2d_max_or_average DUT (.*);

  pool2d_window_checker u_checker (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #12ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 1;
    if (r < 95) return $urandom_range(2, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [p2d_pkg::SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return p2d_pkg::SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // receiver
  initial begin
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_ready = 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
        out_ready = 1'b1;
      end else if (stall_on && $urandom_range(0, 99) < 25) begin
        out_ready = 1'b0;
        repeat (gap_len() - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic send_item(input logic [p2d_pkg::SAMPLE_BITS-1:0] s, input logic re);
    int g, hh, slot;
    bit term;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 99) < 40) begin
      g = gap_len();
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid = 1'b1;
    sample = s;
    row_end = re;
    do @(posedge clk); while (!in_ready);
    fed++;
    hh = plane_rows_raw < 1 ? 1 :
         (plane_rows_raw > p2d_pkg::MAX_PLANE ? p2d_pkg::MAX_PLANE : plane_rows_raw);
    slot = pr % p2d_pkg::MAX_WINDOW;
    if (pc == prefix_len[slot]) prefix_len[slot] = pc + 1;
    term = re || pc >= 1023 || (lw != 0 && pc + 1 >= lw);
    if (term && lw == 0) lw = pc + 1;
    if (term) begin
      pc = 0;
      if (pr >= hh - 1) begin
        pr = 0;
        lw = 0;
        plane_done = 1'b1;
      end else begin
        pr++;
      end
    end else begin
      pc++;
    end
  endtask

  // width only matters for the first row; above 1024 the row ends on its own
  task automatic send_row(input int width, input int early_at);
    logic re;
    do begin
      if (lw == 0) re = (pc == width - 1);
      else if (pc == early_at && prefix_len[pr % p2d_pkg::MAX_WINDOW] >= lw) re = 1'b1;
      else if (pc + 1 >= lw) re = $urandom_range(0, 1);
      else re = 1'b0;
      send_item(pick_sample(), re);
    end while (pc != 0);
  endtask

  task automatic send_plane(input int width, input int early_pct, input int early_col);
    int e;
    plane_done = 1'b0;
    do begin
      e = -1;
      if ($urandom_range(0, 99) < early_pct)
        e = early_col >= 0 ? early_col : $urandom_range(0, lw > 0 ? lw - 1 : 0);
      send_row(width, e);
    end while (!plane_done);
  endtask

  task automatic set_reg(input p2d_pkg::reg_idx_t idx, input int value);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (idx == p2d_pkg::REG_PLANE_HEIGHT) plane_rows_raw = value & 32'h7ff;
  endtask

  task automatic set_all(input int m, input int hh, input int kh, input int kw,
                         input int sh, input int sw, input int mr, input int mc);
    set_reg(p2d_pkg::REG_POOL_MODE, m);
    set_reg(p2d_pkg::REG_PLANE_HEIGHT, hh);
    set_reg(p2d_pkg::REG_WINDOW_HEIGHT, kh);
    set_reg(p2d_pkg::REG_WINDOW_WIDTH, kw);
    set_reg(p2d_pkg::REG_STEP_ROWS, sh);
    set_reg(p2d_pkg::REG_STEP_COLS, sw);
    set_reg(p2d_pkg::REG_MARGIN_ROWS, mr);
    set_reg(p2d_pkg::REG_MARGIN_COLS, mc);
  endtask

  initial begin
    pc = 0;
    pr = 0;
    lw = 0;
    fed = 0;
    plane_rows_raw = 1;
    hold_len = 0;
    idle_on = 1'b1;
    stall_on = 1'b1;
    foreach (prefix_len[i]) prefix_len[i] = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings, then small directed planes
    send_plane(5, 0, -1);
    set_all(1, 3, 3, 3, 1, 1, 1, 1);
    send_plane(4, 0, -1);
    // out-of-range register values
    set_all(0, 0, 0, 15, 0, 15, 7, 7);
    send_plane(10, 0, -1);
    // early row end with more windows than one burst can carry, largest margins
    set_all(0, 2, 8, 8, 1, 1, 7, 7);
    idle_on = 1'b0;
    stall_on = 1'b0;
    send_plane(3, 100, 0);
    // long receiver hold-off while rows keep coming
    idle_on = 1'b1;
    set_all(1, 6, 2, 3, 1, 2, 1, 2);
    hold_len = 3000;
    send_plane(8, 0, -1);
    stall_on = 1'b1;

    while (fed < 150) begin
      set_all($urandom_range(0, 1),
              $urandom_range(0, 99) < 10 ? $urandom_range(0, 2047) % 12 : $urandom_range(1, 8),
              $urandom_range(0, 15), $urandom_range(0, 15),
              $urandom_range(0, 15), $urandom_range(0, 15),
              $urandom_range(0, 7), $urandom_range(0, 7));
      idle_on = $urandom_range(0, 3) != 0;
      stall_on = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(1, 2)) send_plane($urandom_range(1, 12), 20, -1);
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
